// ----- hdl/ikb_pkg.sv -----
// ----------------------------------------------------------------------------
// ikb_pkg
// Shared types, constants and the 8888 to 1555 packing function of the
// indexed colour-keyed blit.
// ----------------------------------------------------------------------------
package ikb_pkg;

   localparam int COORD_BITS_DEFAULT = 12;
   localparam int INDEX_BITS         = 8;
   localparam int PAL_DEPTH          = 256;
   localparam int ENTRY_BITS         = 32;
   localparam int COLOR_BITS         = 16;
   localparam int OFFSET_BITS        = 26;
   localparam int XY_BITS            = 12;
   localparam int PITCH_BITS         = 13;
   localparam int SIZE_BITS          = 13;
   localparam int KEY_BITS           = 8;
   localparam int CSR_ADDR_BITS      = 5;
   localparam int CSR_DATA_BITS      = 32;
   localparam int CSR_SEL_BITS       = 3;

   typedef enum logic {
      OP_LOAD  = 1'b0,
      OP_PIXEL = 1'b1
   } op_type;

   typedef enum logic [CSR_SEL_BITS-1:0] {
      REG_DEST_X          = 3'd0,
      REG_DEST_Y          = 3'd1,
      REG_DEST_PITCH      = 3'd2,
      REG_SOURCE_WIDTH    = 3'd3,
      REG_SOURCE_HEIGHT   = 3'd4,
      REG_KEY_ENABLE      = 3'd5,
      REG_KEY_INDEX       = 3'd6,
      REG_PALETTE_PRESENT = 3'd7
   } csr_reg_type;

   function automatic logic [COLOR_BITS-1:0] pack1555(input logic [ENTRY_BITS-1:0] c);
      pack1555 = {c[31], c[23:19], c[15:11], c[7:3]};
   endfunction

endpackage

// ----- hdl/ikb_ram.sv -----
// ----------------------------------------------------------------------------
// ikb_ram
// Generic single-clock RAM: one write port, one read port, registered read
// data that holds while no read is issued.
// ----------------------------------------------------------------------------
module ikb_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hdl/indexed_keyed_blit_rgb1555_top.sv -----
// ----------------------------------------------------------------------------
// indexed_keyed_blit_rgb1555_top
// Palettized colour-keyed blit of 8-bit indices into a 1555 canvas.
// ----------------------------------------------------------------------------
// Usage:
//   The req_ channel carries items: a load (operation 0) writes the packed
//   1555 form of req_entry into palette slot req_index and gives no result;
//   a pixel (operation 1) gives one rsp_ item with the destination byte
//   offset, the colour, the write enable and a last flag on the final pixel
//   of the rectangle. Pixels arrive in raster order.
//   The accepting edge of a pixel registers the palette RAM read; rsp_valid
//   rises when the output register is loaded from that stage. One item is
//   taken every cycle while req_ready is high, a rate set by the single
//   palette RAM read port and the walk registers, both updated each cycle.
//   The csr_ port holds the rectangle geometry and keying. After each write
//   req_ready drops for one cycle while the origin product and row step are
//   registered.
//   Reset clears the walk and the registers and holds req_ready low for one
//   cycle; the palette keeps no reset value and must be loaded before use.
//   While rsp_ready is low with a result waiting, the pipeline and the
//   palette read hold and req_ready stays low.
// ----------------------------------------------------------------------------
module indexed_keyed_blit_rgb1555_top #(
   parameter int COORD_BITS = ikb_pkg::COORD_BITS_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic                               req_operation,
   input  logic [ikb_pkg::INDEX_BITS-1:0]     req_index,
   input  logic [ikb_pkg::ENTRY_BITS-1:0]     req_entry,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [ikb_pkg::OFFSET_BITS-1:0]    rsp_dest_offset,
   output logic [ikb_pkg::COLOR_BITS-1:0]     rsp_color,
   output logic                               rsp_write_enable,
   output logic                               rsp_last,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [ikb_pkg::CSR_ADDR_BITS-1:0]  csr_paddr,
   input  logic [ikb_pkg::CSR_DATA_BITS-1:0]  csr_pwdata,
   output logic [ikb_pkg::CSR_DATA_BITS-1:0]  csr_prdata,
   output logic                               csr_pready
);

   import ikb_pkg::*;

   localparam int SZ_BITS = COORD_BITS + 1;
   localparam int CMP_BITS = (SZ_BITS > SIZE_BITS) ? SZ_BITS : SIZE_BITS;
   localparam int TOP_SIZE = 1 << COORD_BITS;

   function automatic logic [COORD_BITS:0] eff_size(input logic [SIZE_BITS-1:0] v);
      logic [CMP_BITS-1:0] vx;
      vx = CMP_BITS'(v);
      if (v == '0) begin
         eff_size = SZ_BITS'(1);
      end else if (vx > CMP_BITS'(TOP_SIZE)) begin
         eff_size = SZ_BITS'(TOP_SIZE);
      end else begin
         eff_size = SZ_BITS'(vx);
      end
   endfunction

   // configuration registers
   logic [XY_BITS-1:0]    dest_x_ff, dest_y_ff;
   logic [PITCH_BITS-1:0] dest_pitch_ff;
   logic [SIZE_BITS-1:0]  source_width_ff, source_height_ff;
   logic                  key_enable_ff;
   logic [KEY_BITS-1:0]   key_index_ff;
   logic                  palette_present_ff;
   logic                  cfg_hold_ff;
   logic                  cfg_wr;
   csr_reg_type           csr_sel;

   // derived geometry
   logic [OFFSET_BITS-1:0] origin_ff, origin_in;
   logic [OFFSET_BITS-1:0] row_step_ff, row_step_in;
   logic [COORD_BITS:0]    eff_w_ff, eff_w_in, eff_h_ff, eff_h_in;

   // walk state
   logic [COORD_BITS-1:0]  col_ff, col_in, row_ff, row_in;
   logic [OFFSET_BITS-1:0] next_off_ff, next_off_in;
   logic [OFFSET_BITS-1:0] pix_offset;
   logic                   col_end, row_end, pix_we, pix_last;

   // pipeline
   logic                   adv, acc, acc_pix, acc_load;
   logic                   s1_valid_ff;
   logic [OFFSET_BITS-1:0] s1_offset_ff;
   logic                   s1_we_ff, s1_last_ff;
   logic                   rsp_valid_ff;
   logic [OFFSET_BITS-1:0] rsp_offset_ff;
   logic [COLOR_BITS-1:0]  rsp_color_ff;
   logic                   rsp_we_ff, rsp_last_ff;
   logic [COLOR_BITS-1:0]  pal_rd_data;

   assign csr_pready = 1'b1;
   assign cfg_wr     = csr_psel && csr_penable && csr_pwrite;
   assign csr_sel    = csr_reg_type'(csr_paddr[CSR_ADDR_BITS-1:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         dest_x_ff          <= '0;
         dest_y_ff          <= '0;
         dest_pitch_ff      <= '0;
         source_width_ff    <= SIZE_BITS'(1);
         source_height_ff   <= SIZE_BITS'(1);
         key_enable_ff      <= 1'b0;
         key_index_ff       <= '0;
         palette_present_ff <= 1'b0;
         cfg_hold_ff        <= 1'b1;
      end else begin
         cfg_hold_ff <= cfg_wr;
         if (cfg_wr) begin
            case (csr_sel)
               REG_DEST_X:          dest_x_ff          <= csr_pwdata[XY_BITS-1:0];
               REG_DEST_Y:          dest_y_ff          <= csr_pwdata[XY_BITS-1:0];
               REG_DEST_PITCH:      dest_pitch_ff      <= csr_pwdata[PITCH_BITS-1:0];
               REG_SOURCE_WIDTH:    source_width_ff    <= csr_pwdata[SIZE_BITS-1:0];
               REG_SOURCE_HEIGHT:   source_height_ff   <= csr_pwdata[SIZE_BITS-1:0];
               REG_KEY_ENABLE:      key_enable_ff      <= csr_pwdata[0];
               REG_KEY_INDEX:       key_index_ff       <= csr_pwdata[KEY_BITS-1:0];
               REG_PALETTE_PRESENT: palette_present_ff <= csr_pwdata[0];
               default: ;
            endcase
         end
      end
   end

   always_comb begin
      case (csr_sel)
         REG_DEST_X:          csr_prdata = CSR_DATA_BITS'(dest_x_ff);
         REG_DEST_Y:          csr_prdata = CSR_DATA_BITS'(dest_y_ff);
         REG_DEST_PITCH:      csr_prdata = CSR_DATA_BITS'(dest_pitch_ff);
         REG_SOURCE_WIDTH:    csr_prdata = CSR_DATA_BITS'(source_width_ff);
         REG_SOURCE_HEIGHT:   csr_prdata = CSR_DATA_BITS'(source_height_ff);
         REG_KEY_ENABLE:      csr_prdata = CSR_DATA_BITS'(key_enable_ff);
         REG_KEY_INDEX:       csr_prdata = CSR_DATA_BITS'(key_index_ff);
         REG_PALETTE_PRESENT: csr_prdata = CSR_DATA_BITS'(palette_present_ff);
         default:             csr_prdata = '0;
      endcase
   end

   // register origin product and row step once per cycle
   always_comb begin
      eff_w_in    = eff_size(source_width_ff);
      eff_h_in    = eff_size(source_height_ff);
      origin_in   = OFFSET_BITS'(OFFSET_BITS'(dest_y_ff) * OFFSET_BITS'(dest_pitch_ff))
                  + OFFSET_BITS'({dest_x_ff, 1'b0});
      row_step_in = OFFSET_BITS'({dest_pitch_ff[PITCH_BITS-1:1], 1'b0})
                  + OFFSET_BITS'(2)
                  - OFFSET_BITS'({eff_w_in, 1'b0});
   end

   always_ff @(posedge clock) begin
      origin_ff   <= origin_in;
      row_step_ff <= row_step_in;
      eff_w_ff    <= eff_w_in;
      eff_h_ff    <= eff_h_in;
   end

   assign adv       = !rsp_valid_ff || rsp_ready;
   assign req_ready = adv && !cfg_hold_ff;
   assign acc       = req_valid && req_ready;
   assign acc_pix   = acc && (op_type'(req_operation) == OP_PIXEL);
   assign acc_load  = acc && (op_type'(req_operation) == OP_LOAD);

   // advance the raster walk
   always_comb begin
      pix_offset = (col_ff == '0 && row_ff == '0) ? origin_ff : next_off_ff;
      col_end    = (SZ_BITS'(col_ff) + SZ_BITS'(1)) >= eff_w_ff;
      row_end    = (SZ_BITS'(row_ff) + SZ_BITS'(1)) >= eff_h_ff;
      pix_last   = col_end && row_end;
      pix_we     = palette_present_ff && !(key_enable_ff && (req_index == key_index_ff));
      col_in      = col_ff;
      row_in      = row_ff;
      next_off_in = next_off_ff;
      if (acc_pix) begin
         if (col_end) begin
            col_in      = '0;
            next_off_in = pix_offset + row_step_ff;
            row_in      = row_end ? '0 : COORD_BITS'(row_ff + 1'b1);
         end else begin
            col_in      = COORD_BITS'(col_ff + 1'b1);
            next_off_in = pix_offset + OFFSET_BITS'(2);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff       <= '0;
         row_ff       <= '0;
         next_off_ff  <= '0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         col_ff      <= col_in;
         row_ff      <= row_in;
         next_off_ff <= next_off_in;
         if (adv) begin
            s1_valid_ff  <= acc_pix;
            rsp_valid_ff <= s1_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (acc_pix) begin
         s1_offset_ff <= pix_offset;
         s1_we_ff     <= pix_we;
         s1_last_ff   <= pix_last;
      end
      if (adv && s1_valid_ff) begin
         rsp_offset_ff <= s1_offset_ff;
         rsp_color_ff  <= s1_we_ff ? pal_rd_data : '0;
         rsp_we_ff     <= s1_we_ff;
         rsp_last_ff   <= s1_last_ff;
      end
   end

   ikb_ram #(
      .WIDTH (COLOR_BITS),
      .DEPTH (PAL_DEPTH)
   ) u_palette (
      .clock   (clock),
      .wr_en   (acc_load),
      .wr_addr (req_index),
      .wr_data (pack1555(req_entry)),
      .rd_en   (acc_pix),
      .rd_addr (req_index),
      .rd_data (pal_rd_data)
   );

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_dest_offset  = rsp_offset_ff;
   assign rsp_color        = rsp_color_ff;
   assign rsp_write_enable = rsp_we_ff;
   assign rsp_last         = rsp_last_ff;

   a_hold_after_cfg: assert property (@(posedge clock) disable iff (reset)
      cfg_wr |=> !(req_valid && req_ready))
      else $error("item accepted in the cycle after a register write");

   a_last_rewinds: assert property (@(posedge clock) disable iff (reset)
      (acc_pix && pix_last) |=> (col_ff == '0 && row_ff == '0))
      else $error("walk not rewound after the last pixel");

   a_masked_color: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_we_ff) |-> (rsp_color_ff == '0))
      else $error("suppressed item carries a colour");

   a_stage_moves: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && adv) |=> rsp_valid_ff)
      else $error("pixel lost between palette read and output");

endmodule
